// ===== hdl/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types, constants and character decode for the integer string parser.
// ----------------------------------------------------------------------------
package isp_pkg;

   localparam int unsigned MAX_DEC_DIGITS = 19;
   localparam int unsigned MAX_HEX_DIGITS = 16;
   localparam int unsigned CNT_W          = 5;

   localparam logic [1:0] MODE_UDEC   = 2'd0;
   localparam logic [1:0] MODE_SDEC   = 2'd1;
   localparam logic [1:0] MODE_HEX    = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;

   localparam logic [CNT_W-1:0] DEC_LIMIT = CNT_W'(MAX_DEC_DIGITS);
   localparam logic [CNT_W-1:0] HEX_LIMIT = CNT_W'(MAX_HEX_DIGITS);

   typedef struct packed {
      logic             valid;
      logic [3:0]       value;
   } digit_type;

   // running per-string parse state
   typedef struct packed {
      logic [63:0]      acc;
      logic [CNT_W-1:0] cnt;
      logic             neg;
      logic             failed;
      logic [1:0]       mode;
   } parse_type;

   // finished string, waiting for range check and sign fix-up
   typedef struct packed {
      logic [63:0]      acc;
      logic             neg;
      logic             good;
      logic [1:0]       mode;
   } pend_type;

   function automatic digit_type dec_digit(input logic [7:0] c);
      digit_type d;
      d.valid = (c >= 8'h30) && (c <= 8'h39);
      d.value = c[3:0];
      return d;
   endfunction

   function automatic digit_type hex_digit(input logic [7:0] c);
      digit_type d;
      d.valid = 1'b0;
      d.value = 4'd0;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         d.valid = 1'b1;
         d.value = c[3:0];
      end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
         // a-f and A-F share the low three bits: 1..6
         d.valid = 1'b1;
         d.value = 4'd9 + {1'b0, c[2:0]};
      end
      return d;
   endfunction

endpackage

// ===== hdl/integer_string_parser_top.sv =====
// One byte of an ASCII number string is taken per cycle while req_stall is low,
// with no gaps needed between bytes or between strings. Mode is sampled on the
// first byte of each string. After the last byte is accepted into the input
// register, the parse-state update and capture of the finished string happen
// together, then the range check is registered into the output register; a
// stalled result does not block bytes of the next string from flowing in
// until the internal stages behind the output fill up.
// ----------------------------------------------------------------------------
// integer_string_parser_top
// Decimal (unsigned or signed) and hex string to 64-bit integer converter.
// ----------------------------------------------------------------------------
module integer_string_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   input  logic [1:0]  req_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value_out,
   output logic        rsp_ok
);

   // input register
   logic        a_valid_ff, a_valid_in;
   logic [7:0]  a_char_ff;
   logic        a_last_ff;
   logic [1:0]  a_mode_ff;

   // parse state
   isp_pkg::parse_type st_ff, st_in;
   logic               start_ff;

   // finished-string stage
   logic               b_valid_ff, b_valid_in;
   isp_pkg::pend_type  b_ff, b_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic out_load, b_free, a_take, a_free, req_take;

   assign out_load = b_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign b_free   = !b_valid_ff || out_load;
   assign a_take   = a_valid_ff && (!a_last_ff || b_free);
   assign a_free   = !a_valid_ff || a_take;
   assign req_stall = !a_free;
   assign req_take  = req_valid && a_free;

   isp_step u_step (
      .char_in (a_char_ff),
      .mode    (a_mode_ff),
      .first   (start_ff),
      .cur     (st_ff),
      .nxt     (st_in)
   );

   always_comb begin
      b_in.acc  = st_in.acc;
      b_in.neg  = st_in.neg;
      b_in.good = !st_in.failed && (st_in.cnt != '0);
      b_in.mode = st_in.mode;
   end

   isp_finish u_finish (
      .pend      (b_ff),
      .value_out (rsp_value_in),
      .ok        (rsp_ok_in)
   );

   assign a_valid_in   = req_take || (a_valid_ff && !a_take);
   assign b_valid_in   = (a_take && a_last_ff) || (b_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 1'b1;
         st_ff        <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (a_take) begin
            start_ff <= a_last_ff;
            st_ff    <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_char_ff <= req_char_in;
         a_last_ff <= req_last_char;
         a_mode_ff <= req_mode;
      end
      if (a_take && a_last_ff) begin
         b_ff <= b_in;
      end
      if (out_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_ok_ff    <= rsp_ok_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_ok        = rsp_ok_ff;

endmodule

// ===== hdl/isp_step.sv =====
// ----------------------------------------------------------------------------
// isp_step
// Next parse state for one character: sign, digit accumulate or failure.
// ----------------------------------------------------------------------------
module isp_step (
   input  logic [7:0]         char_in,
   input  logic [1:0]         mode,
   input  logic               first,
   input  isp_pkg::parse_type cur,
   output isp_pkg::parse_type nxt
);

   isp_pkg::parse_type base;
   isp_pkg::digit_type dig;
   logic               is_hex;
   logic               is_sign;
   logic [isp_pkg::CNT_W-1:0] limit;
   logic [63:0]        acc_dec;
   logic [63:0]        acc_hex;

   always_comb begin
      if (first) begin
         base.acc    = '0;
         base.cnt    = '0;
         base.neg    = 1'b0;
         base.failed = 1'b0;
         base.mode   = mode;
      end else begin
         base = cur;
      end
   end

   assign is_hex  = (base.mode == isp_pkg::MODE_HEX);
   assign dig     = is_hex ? isp_pkg::hex_digit(char_in) : isp_pkg::dec_digit(char_in);
   assign limit   = is_hex ? isp_pkg::HEX_LIMIT : isp_pkg::DEC_LIMIT;
   assign is_sign = (char_in == isp_pkg::CHAR_MINUS) || (char_in == isp_pkg::CHAR_PLUS);

   // acc*10 + d as two shifted terms plus the digit
   assign acc_dec = (base.acc << 3) + (base.acc << 1) + {60'd0, dig.value};
   assign acc_hex = {base.acc[59:0], dig.value};

   always_comb begin
      nxt = base;
      if (!base.failed) begin
         priority if (base.mode == isp_pkg::MODE_UNUSED) begin
            nxt.failed = 1'b1;
         end else if ((base.mode == isp_pkg::MODE_SDEC) && first && is_sign) begin
            nxt.neg = (char_in == isp_pkg::CHAR_MINUS);
         end else if (!dig.valid || (base.cnt >= limit)) begin
            nxt.failed = 1'b1;
         end else begin
            nxt.acc = is_hex ? acc_hex : acc_dec;
            nxt.cnt = base.cnt + 1'b1;
         end
      end
   end

endmodule

// ===== hdl/isp_finish.sv =====
// ----------------------------------------------------------------------------
// isp_finish
// Signed-mode range check and two's complement of a finished string; zero on failure.
// ----------------------------------------------------------------------------
module isp_finish (
   input  isp_pkg::pend_type pend,
   output logic [63:0]       value_out,
   output logic              ok
);

   logic        good;
   logic [63:0] val;

   always_comb begin
      good = pend.good;
      val  = pend.acc;
      if (pend.good && (pend.mode == isp_pkg::MODE_SDEC)) begin
         if (pend.neg) begin
            // magnitude above 2^63 does not fit
            if (pend.acc[63] && (|pend.acc[62:0])) begin
               good = 1'b0;
            end else begin
               val = 64'd0 - pend.acc;
            end
         end else if (pend.acc[63]) begin
            good = 1'b0;
         end
      end
   end

   assign value_out = good ? val : 64'd0;
   assign ok        = good;

endmodule

// ===== hdl/isp_checker.sv =====
// ----------------------------------------------------------------------------
// isp_checker
// Port-level checks for the integer string parser.
// ----------------------------------------------------------------------------
module isp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_value_out,
   input logic        rsp_ok
);

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_out) && $stable(rsp_ok))
      else $error("result beat changed while stalled");

   // failed strings report a zero value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_value_out == 64'd0)
      else $error("nonzero value with ok low");

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a beat needs a byte to pass the input, finished-string and output registers,
   // so none can show as soon as reset is released
   a_reset_latency: assert property (@(posedge clock)
      $past(reset) && !reset |=> !rsp_valid)
      else $error("result too soon after reset");

endmodule

bind integer_string_parser_top isp_checker u_isp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_value_out (rsp_value_out),
   .rsp_ok        (rsp_ok)
);
